>>> hw/rtl/vipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_pkg
// Shared constants, command codes and control types of the vectored
// interrupt priority controller.
// ----------------------------------------------------------------------------
package vipc_pkg;

  localparam int Levels = 4;
  localparam int Slots  = 32;

  localparam int CMD_W   = 3;
  localparam int LEVEL_W = 2;
  localparam int IPL_W   = 5;
  localparam int MASK_W  = 32;
  localparam int SLOT_W  = 5;
  localparam int VIN_W   = 9;
  localparam int VEC_W   = 10;

  localparam int LVL_IW  = (Levels > 1) ? $clog2(Levels) : 1;
  localparam int SLOT_IW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int Entries = Levels * Slots;
  localparam int ADDR_W  = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int PRI_W   = IPL_W + 1;

  localparam logic [IPL_W-1:0] IPL_MAX      = '1;
  localparam logic [IPL_W-1:0] BASE_IPL_RST = IPL_W'(20);

  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;
  localparam logic [CFG_AW-3:0] CFG_IDX_BASE = '0;

  localparam logic [CMD_W-1:0] CMD_RAISE  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CANCEL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POLL   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ACK    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SETVEC = 3'd4;

  typedef struct packed {
    logic cap;
    logic exec;
    logic rdat;
    logic load;
  } ctrl_t;

  typedef struct packed {
    logic ack_hit;
  } status_t;

endpackage

>>> hw/rtl/vipc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_ram
// Generic single-port RAM with a registered read.
// ----------------------------------------------------------------------------
module vipc_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [W-1:0]             wdata,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en && we) begin
      mem[addr] <= wdata;
    end
    if (en && !we) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/vipc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_cfg
// Configuration register file holding the base priority level.
// ----------------------------------------------------------------------------
module vipc_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vipc_pkg::CFG_AW-1:0]         paddr,
  input  logic [vipc_pkg::CFG_DW-1:0]         pwdata,
  output logic [vipc_pkg::CFG_DW-1:0]         prdata,
  output logic                                pready,
  output logic [vipc_pkg::IPL_W-1:0]          base_ipl
);

  logic [vipc_pkg::IPL_W-1:0] base_ipl_r;
  logic                       sel_base;

  assign sel_base = (paddr[vipc_pkg::CFG_AW-1:2] == vipc_pkg::CFG_IDX_BASE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_ipl_r <= vipc_pkg::BASE_IPL_RST;
    end else if (psel && penable && pwrite && sel_base) begin
      base_ipl_r <= pwdata[vipc_pkg::IPL_W-1:0];
    end
  end

  assign prdata   = sel_base ? vipc_pkg::CFG_DW'(base_ipl_r) : '0;
  assign pready   = 1'b1;
  assign base_ipl = base_ipl_r;

endmodule

>>> hw/rtl/vipc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_dp
// Datapath: transaction registers, pending masks, vector table with valid
// bits, poll and acknowledge encoders, and the result register.
// ----------------------------------------------------------------------------
module vipc_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vipc_pkg::ctrl_t                ctrl,
  output vipc_pkg::status_t              status,
  input  logic [vipc_pkg::IPL_W-1:0]     base_ipl,
  input  logic [vipc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [vipc_pkg::LEVEL_W-1:0]   in_level,
  input  logic [vipc_pkg::IPL_W-1:0]     in_current_ipl,
  input  logic [vipc_pkg::MASK_W-1:0]    in_req_mask,
  input  logic [vipc_pkg::SLOT_W-1:0]    in_slot,
  input  logic [vipc_pkg::VIN_W-1:0]     in_vector_in,
  input  logic                           in_has_csr,
  output logic [vipc_pkg::IPL_W-1:0]     out_irq_ipl,
  output logic [vipc_pkg::VEC_W-1:0]     out_vector_out,
  output logic                           out_found
);

  localparam int L  = vipc_pkg::Levels;
  localparam int S  = vipc_pkg::Slots;
  localparam int LW = vipc_pkg::LVL_IW;
  localparam int SW = vipc_pkg::SLOT_IW;
  localparam int AW = vipc_pkg::ADDR_W;
  localparam int PW = vipc_pkg::PRI_W;

  logic [vipc_pkg::CMD_W-1:0]   cmd_r;
  logic [vipc_pkg::LEVEL_W-1:0] lvl_r;
  logic [vipc_pkg::IPL_W-1:0]   cur_r;
  logic [vipc_pkg::MASK_W-1:0]  msk_r;
  logic [vipc_pkg::SLOT_W-1:0]  slot_r;
  logic [vipc_pkg::VIN_W-1:0]   vin_r;
  logic                         csr_r;

  logic [S-1:0] pend_r   [L];
  logic [S-1:0] pend_nxt [L];
  logic [vipc_pkg::Entries-1:0] vld_r;
  logic                         rd_vld_r;

  logic [vipc_pkg::IPL_W-1:0] res_ipl_r;
  logic [vipc_pkg::VEC_W-1:0] res_vec_r;
  logic                       res_found_r;
  logic [vipc_pkg::IPL_W-1:0] out_ipl_r;
  logic [vipc_pkg::VEC_W-1:0] out_vec_r;
  logic                       out_found_r;

  logic                       level_ok;
  logic                       slot_ok;
  logic [LW-1:0]              lvl_idx;
  logic [SW-1:0]              slot_idx;
  logic [S-1:0]               pend_sel;
  logic [SW-1:0]              low_idx;
  logic                       ack_hit;
  logic                       vec_we;
  logic                       ram_en;
  logic [AW-1:0]              ram_addr;
  logic [vipc_pkg::VEC_W-1:0] ram_rdata;
  logic [vipc_pkg::IPL_W-1:0] poll_ipl;
  logic                       poll_hit;

  assign level_ok = (int'(lvl_r) < L);
  assign slot_ok  = (int'(slot_r) < S);
  assign lvl_idx  = LW'(lvl_r);
  assign slot_idx = SW'(slot_r);
  assign pend_sel = level_ok ? pend_r[lvl_idx] : '0;

  always_comb begin
    low_idx = '0;
    for (int s = S - 1; s >= 0; s--) begin
      if (pend_sel[s]) begin
        low_idx = SW'(s);
      end
    end
  end

  assign ack_hit = (cmd_r == vipc_pkg::CMD_ACK) && (pend_sel != '0);
  assign status.ack_hit = ack_hit;

  always_comb begin
    logic [PW-1:0] pri;
    logic          stop;
    poll_ipl = '0;
    poll_hit = 1'b0;
    stop     = 1'b0;
    for (int i = L - 1; i >= 0; i--) begin
      pri = PW'(base_ipl) + PW'(i);
      if (!stop) begin
        if (pri <= PW'(cur_r)) begin
          stop = 1'b1;
        end else if (pend_r[i] != '0) begin
          stop     = 1'b1;
          poll_hit = 1'b1;
          poll_ipl = (pri > PW'(vipc_pkg::IPL_MAX)) ? vipc_pkg::IPL_MAX
                                                    : pri[vipc_pkg::IPL_W-1:0];
        end
      end
    end
  end

  assign vec_we   = ctrl.exec && (cmd_r == vipc_pkg::CMD_SETVEC) && level_ok && slot_ok;
  assign ram_en   = vec_we || (ctrl.exec && ack_hit);
  assign ram_addr = (cmd_r == vipc_pkg::CMD_SETVEC)
                  ? AW'(int'(lvl_idx) * S + int'(slot_idx))
                  : AW'(int'(lvl_idx) * S + int'(low_idx));

  vipc_ram #(
    .W     (vipc_pkg::VEC_W),
    .DEPTH (vipc_pkg::Entries)
  ) u_vec_ram (
    .clk   (clk),
    .en    (ram_en),
    .we    (vec_we),
    .addr  (ram_addr),
    .wdata ({csr_r, vin_r}),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int i = 0; i < L; i++) begin
      pend_nxt[i] = pend_r[i];
    end
    if (ctrl.exec && level_ok) begin
      case (cmd_r)
        vipc_pkg::CMD_RAISE:  pend_nxt[lvl_idx] = pend_r[lvl_idx] | msk_r[S-1:0];
        vipc_pkg::CMD_CANCEL: pend_nxt[lvl_idx] = pend_r[lvl_idx] & ~msk_r[S-1:0];
        vipc_pkg::CMD_ACK: begin
          if (ack_hit) begin
            pend_nxt[lvl_idx][low_idx] = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < L; i++) begin
        pend_r[i] <= '0;
      end
      vld_r <= '0;
    end else begin
      for (int i = 0; i < L; i++) begin
        pend_r[i] <= pend_nxt[i];
      end
      if (vec_we) begin
        vld_r[ram_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.cap) begin
      cmd_r  <= in_cmd;
      lvl_r  <= in_level;
      cur_r  <= in_current_ipl;
      msk_r  <= in_req_mask;
      slot_r <= in_slot;
      vin_r  <= in_vector_in;
      csr_r  <= in_has_csr;
    end
    if (ctrl.exec) begin
      rd_vld_r    <= vld_r[ram_addr];
      res_ipl_r   <= (cmd_r == vipc_pkg::CMD_POLL) ? poll_ipl : '0;
      res_vec_r   <= '0;
      res_found_r <= ((cmd_r == vipc_pkg::CMD_POLL) && poll_hit) || ack_hit;
    end
    if (ctrl.rdat) begin
      res_vec_r <= rd_vld_r ? ram_rdata : '0;
    end
    if (ctrl.load) begin
      out_ipl_r   <= res_ipl_r;
      out_vec_r   <= res_vec_r;
      out_found_r <= res_found_r;
    end
  end

  assign out_irq_ipl    = out_ipl_r;
  assign out_vector_out = out_vec_r;
  assign out_found      = out_found_r;

endmodule

>>> hw/rtl/vipc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_ctrl
// Sequencer: accepts one transaction, steps it through execute and, for an
// acknowledge that finds a pending slot, vector read, and hands the result to the output register.
// ----------------------------------------------------------------------------
module vipc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output vipc_pkg::ctrl_t   ctrl,
  input  vipc_pkg::status_t status
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_RDAT = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.cap  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = status.ack_hit ? S_RDAT : S_DONE;
      end
      S_RDAT: begin
        ctrl.rdat = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ctrl.load     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/vectored_interrupt_priority_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vectored_interrupt_priority_controller
// Each transaction steps through the execute state, then, for an acknowledge
// that finds a pending slot, the registered vector RAM read, and waits in the
// done state until the output register is free. The sequencer takes no new
// transaction until it has handed the current result to the output register.
// Reset (synchronous, active low) clears all pending masks and vector valid
// bits at once and sets the base priority level to 20.
// ----------------------------------------------------------------------------
module vectored_interrupt_priority_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [vipc_pkg::CMD_W-1:0]     in_cmd,
  input  logic [vipc_pkg::LEVEL_W-1:0]   in_level,
  input  logic [vipc_pkg::IPL_W-1:0]     in_current_ipl,
  input  logic [vipc_pkg::MASK_W-1:0]    in_req_mask,
  input  logic [vipc_pkg::SLOT_W-1:0]    in_slot,
  input  logic [vipc_pkg::VIN_W-1:0]     in_vector_in,
  input  logic                           in_has_csr,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [vipc_pkg::IPL_W-1:0]     out_irq_ipl,
  output logic [vipc_pkg::VEC_W-1:0]     out_vector_out,
  output logic                           out_found,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [vipc_pkg::CFG_AW-1:0]    cfg_paddr,
  input  logic [vipc_pkg::CFG_DW-1:0]    cfg_pwdata,
  output logic [vipc_pkg::CFG_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready
);

  vipc_pkg::ctrl_t            ctrl;
  vipc_pkg::status_t          status;
  logic [vipc_pkg::IPL_W-1:0] base_ipl;

  vipc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .base_ipl (base_ipl)
  );

  vipc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl),
    .status    (status)
  );

  vipc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .base_ipl       (base_ipl),
    .in_cmd         (in_cmd),
    .in_level       (in_level),
    .in_current_ipl (in_current_ipl),
    .in_req_mask    (in_req_mask),
    .in_slot        (in_slot),
    .in_vector_in   (in_vector_in),
    .in_has_csr     (in_has_csr),
    .out_irq_ipl    (out_irq_ipl),
    .out_vector_out (out_vector_out),
    .out_found      (out_found)
  );

endmodule

>>> hw/rtl/vipc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vipc_checker
// Port-level checks of the controller, attached to the top level by bind.
// ----------------------------------------------------------------------------
module vipc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [vipc_pkg::IPL_W-1:0]   out_irq_ipl,
  input logic [vipc_pkg::VEC_W-1:0]   out_vector_out,
  input logic                         out_found
);

  // A held result keeps its value until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_irq_ipl)
      && $stable(out_vector_out) && $stable(out_found))
    else $error("result changed while stalled");

  // Only one transaction is in progress at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while busy");

  // A result without a hit carries no priority and no vector.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_irq_ipl == '0 && out_vector_out == '0)
    else $error("non-zero result without a hit");

  // Poll and acknowledge results never appear together.
  a_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_irq_ipl != '0 |-> out_found && out_vector_out == '0)
    else $error("poll result mixed with vector");

endmodule

bind vectored_interrupt_priority_controller vipc_checker u_vipc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_irq_ipl    (out_irq_ipl),
  .out_vector_out (out_vector_out),
  .out_found      (out_found)
);
